FILE: sv/csr_bds_pkg.sv
package csr_bds_pkg;

  // Field widths
  localparam int unsigned VAL_W    = 64;
  localparam int unsigned COL_W    = 20;
  localparam int unsigned ROW_W    = 20;
  localparam int unsigned LIM_W    = 21;
  localparam int unsigned CNT_W    = 25;
  localparam int unsigned PART_W   = 6;
  localparam int unsigned NPART_W  = 7;
  localparam int unsigned CFGIDX_W = 2;
  localparam int unsigned CFGDAT_W = 21;

  localparam int unsigned MAX_PARTS = 64;

  // Results one nonzero can cause: closing record, entry, final record
  localparam int unsigned RES_PER_ITEM = 3;
  localparam int unsigned RES_N_W      = 2;

  // Configuration register indexes
  localparam logic [CFGIDX_W-1:0] CFG_NUM_ROWS      = 2'd0;
  localparam logic [CFGIDX_W-1:0] CFG_NUM_PARTS     = 2'd1;
  localparam logic [CFGIDX_W-1:0] CFG_ROWS_PER_PART = 2'd2;
  localparam logic [CFGIDX_W-1:0] CFG_LOWER_MODE    = 2'd3;

  typedef enum logic [1:0] {
    KIND_D       = 2'd0,
    KIND_R       = 2'd1,
    KIND_ROW_END = 2'd2
  } kind_e;

  typedef struct packed {
    logic [LIM_W-1:0]   num_rows;
    logic [NPART_W-1:0] num_parts;
    logic [LIM_W-1:0]   rows_per_part;
    logic               lower_mode;
  } cfg_t;

  typedef struct packed {
    kind_e              kind;
    logic [VAL_W-1:0]   value;
    logic [COL_W-1:0]   column;
    logic [ROW_W-1:0]   row;
    logic [CNT_W-1:0]   d_total;
    logic [CNT_W-1:0]   r_total;
    logic               part_end;
    logic               last;
  } res_t;

  // Partition count clamped to 1..MAX_PARTS
  function automatic logic [NPART_W-1:0] eff_parts(input cfg_t cfg);
    logic [NPART_W-1:0] p;
    p = cfg.num_parts;
    if (p == '0) begin
      p = NPART_W'(1);
    end else if (p > NPART_W'(MAX_PARTS)) begin
      p = NPART_W'(MAX_PARTS);
    end
    return p;
  endfunction

  // End row of partition idx that starts at start
  function automatic logic [LIM_W-1:0] limit_for(input cfg_t cfg,
                                                 input logic [NPART_W-1:0] idx,
                                                 input logic [LIM_W-1:0] start);
    logic [LIM_W-1:0] rpp;
    logic [LIM_W:0]   sum;
    logic [LIM_W-1:0] lim;
    rpp = (cfg.rows_per_part == '0) ? LIM_W'(1) : cfg.rows_per_part;
    sum = {1'b0, start} + {1'b0, rpp};
    if ((idx + NPART_W'(1)) >= eff_parts(cfg)) begin
      lim = cfg.num_rows;
    end else if (sum[LIM_W]) begin
      lim = '1;
    end else begin
      lim = sum[LIM_W-1:0];
    end
    return lim;
  endfunction

endpackage

FILE: sv/csr_bds_split.sv
module csr_bds_split (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  csr_bds_pkg::cfg_t                          cfg_i,
  input  logic                                       accept_i,
  input  logic [csr_bds_pkg::VAL_W-1:0]              value_i,
  input  logic [csr_bds_pkg::COL_W-1:0]              column_i,
  input  logic                                       row_first_i,
  input  logic                                       matrix_last_i,
  output csr_bds_pkg::res_t                          res_o [csr_bds_pkg::RES_PER_ITEM],
  output logic [csr_bds_pkg::RES_N_W-1:0]            res_n_o
);
  import csr_bds_pkg::*;

  // Matrix walk state
  logic [ROW_W-1:0]  row_q, row_d;
  logic [PART_W-1:0] pidx_q, pidx_d;
  logic [LIM_W-1:0]  pstart_q, pstart_d;
  logic [LIM_W-1:0]  plim_q, plim_d;
  logic [CNT_W-1:0]  d_cnt_q, d_cnt_d;
  logic [CNT_W-1:0]  r_cnt_q, r_cnt_d;
  logic              started_q;

  res_t              pre, ent, post;
  logic              pre_v, ent_v, post_v;
  logic              pend_pre;
  logic [NPART_W-1:0] pidx_nx;
  logic [LIM_W-1:0]  col_ext;
  logic [LIM_W-1:0]  col_loc;

  // Row close, classification and row-end records for one word
  always_comb begin
    row_d    = row_q;
    pidx_d   = pidx_q;
    pstart_d = pstart_q;
    plim_d   = plim_q;
    d_cnt_d  = d_cnt_q;
    r_cnt_d  = r_cnt_q;
    pre_v    = 1'b0;
    ent_v    = 1'b0;
    post_v   = 1'b0;
    pend_pre = 1'b0;
    pidx_nx  = {1'b0, pidx_q} + NPART_W'(1);
    col_ext  = {1'b0, column_i};

    if (!started_q) begin
      // first word of a matrix opens row 0
      row_d    = '0;
      pidx_d   = '0;
      pstart_d = '0;
      plim_d   = limit_for(cfg_i, '0, '0);
      d_cnt_d  = '0;
      r_cnt_d  = '0;
    end else if (row_first_i) begin
      pend_pre = (({1'b0, row_q} + LIM_W'(1)) == plim_q);
      pre_v    = 1'b1;
      row_d    = row_q + ROW_W'(1);
      if (pend_pre && (pidx_nx < eff_parts(cfg_i))) begin
        pidx_d   = pidx_nx[PART_W-1:0];
        pstart_d = plim_q;
        plim_d   = limit_for(cfg_i, pidx_nx, plim_q);
      end
    end

    pre.kind     = KIND_ROW_END;
    pre.value    = '0;
    pre.column   = '0;
    pre.row      = row_q;
    pre.d_total  = d_cnt_q;
    pre.r_total  = r_cnt_q;
    pre.part_end = pend_pre;
    pre.last     = 1'b0;

    col_loc = col_ext - pstart_d;
    ent.kind = KIND_D;
    ent.column = col_loc[COL_W-1:0];
    if (col_ext >= pstart_d && col_ext < plim_d) begin
      ent_v   = 1'b1;
      d_cnt_d = (&d_cnt_d) ? d_cnt_d : d_cnt_d + CNT_W'(1);
    end else if ((!cfg_i.lower_mode && col_ext >= plim_d) ||
                 (cfg_i.lower_mode && col_ext < pstart_d)) begin
      ent_v      = 1'b1;
      ent.kind   = KIND_R;
      ent.column = column_i;
      r_cnt_d    = (&r_cnt_d) ? r_cnt_d : r_cnt_d + CNT_W'(1);
    end
    ent.value    = value_i;
    ent.row      = row_d;
    ent.d_total  = d_cnt_d;
    ent.r_total  = r_cnt_d;
    ent.part_end = 1'b0;
    ent.last     = 1'b0;

    post_v        = matrix_last_i;
    post.kind     = KIND_ROW_END;
    post.value    = '0;
    post.column   = '0;
    post.row      = row_d;
    post.d_total  = d_cnt_d;
    post.r_total  = r_cnt_d;
    post.part_end = (({1'b0, row_d} + LIM_W'(1)) == plim_d);
    post.last     = 1'b1;

    pre.last = !ent_v && !post_v;
    ent.last = !post_v;
  end

  // Pack valid results to the front
  always_comb begin
    res_o[0] = pre_v ? pre : (ent_v ? ent : post);
    res_o[1] = pre_v ? (ent_v ? ent : post) : post;
    res_o[2] = post;
    res_n_o  = RES_N_W'(pre_v) + RES_N_W'(ent_v) + RES_N_W'(post_v);
  end

  // State update; matrix end returns to the start state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q     <= '0;
      pidx_q    <= '0;
      pstart_q  <= '0;
      plim_q    <= LIM_W'(1);
      d_cnt_q   <= '0;
      r_cnt_q   <= '0;
      started_q <= 1'b0;
    end else if (accept_i) begin
      if (matrix_last_i) begin
        row_q     <= '0;
        pidx_q    <= '0;
        pstart_q  <= '0;
        plim_q    <= limit_for(cfg_i, '0, '0);
        d_cnt_q   <= '0;
        r_cnt_q   <= '0;
        started_q <= 1'b0;
      end else begin
        row_q     <= row_d;
        pidx_q    <= pidx_d;
        pstart_q  <= pstart_d;
        plim_q    <= plim_d;
        d_cnt_q   <= d_cnt_d;
        r_cnt_q   <= r_cnt_d;
        started_q <= 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && matrix_last_i |=> !started_q && d_cnt_q == '0 && r_cnt_q == '0)
    else $error("matrix end did not restart state");
  a_d_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    started_q && $past(started_q) |-> d_cnt_q >= $past(d_cnt_q))
    else $error("D count went backwards inside a matrix");
  a_part_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    started_q && $past(started_q) |-> pstart_q >= $past(pstart_q))
    else $error("partition start went backwards inside a matrix");
`endif

endmodule

FILE: sv/csr_bds_rq.sv
module csr_bds_rq (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push_i,
  input  csr_bds_pkg::res_t                res_i [csr_bds_pkg::RES_PER_ITEM],
  input  logic [csr_bds_pkg::RES_N_W-1:0]  res_n_i,
  output logic                             in_ready_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output csr_bds_pkg::res_t                res_o
);
  import csr_bds_pkg::*;

  localparam int unsigned DEPTH = 4;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned LVL_W = $clog2(DEPTH + 1);

  res_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [LVL_W-1:0] cnt_q, cnt_d;
  logic [LVL_W-1:0] push_n;
  logic             pop;

  // Room for a full burst of results
  assign in_ready_o  = cnt_q <= LVL_W'(DEPTH - RES_PER_ITEM);
  assign out_valid_o = cnt_q != '0;
  assign res_o       = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;
  assign push_n      = push_i ? LVL_W'(res_n_i) : '0;
  assign cnt_d       = cnt_q + push_n - LVL_W'(pop);

  // Burst write of up to three results
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < RES_PER_ITEM; i++) begin
      if (push_i && (RES_N_W'(i) < res_n_i)) begin
        mem_q[wr_ptr_q + PTR_W'(i)] <= res_i[i];
      end
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PTR_W'(push_n);
      rd_ptr_q <= rd_ptr_q + PTR_W'(pop);
      cnt_q    <= cnt_d;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= LVL_W'(DEPTH))
    else $error("result queue overflow");
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> cnt_q <= LVL_W'(DEPTH - RES_PER_ITEM))
    else $error("push without room for a full burst");
  a_drain_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !push_i |=> cnt_q <= $past(cnt_q))
    else $error("fill level grew without a push");
`endif

endmodule

FILE: sv/csr_block_diagonal_splitter.sv
// Channel  Handshake                     Payload
// in       in_valid_i / in_ready_o       value_i column_i row_first_i matrix_last_i
// out      out_valid_o / out_ready_i     kind_o entry_value_o entry_column_o row_index_o
//                                        d_total_o r_total_o part_end_o last_o
// cfg      cfg_valid_i / cfg_ready_o     cfg_index_i cfg_data_i
//
// One nonzero word is accepted per cycle while the queue has room; its results are
// written into the result queue. Each word gives zero to three result words, drained
// one per cycle while out_ready_i is high, through a four-entry result queue; the input
// stalls while the queue lacks room for three. Steady rate is one word per cycle
// when each word gives at most one result and out_ready_i stays high. Reset clears
// the walk state and loads the register defaults; the config port is always ready.
module csr_block_diagonal_splitter (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [csr_bds_pkg::CFGIDX_W-1:0]     cfg_index_i,
  input  logic [csr_bds_pkg::CFGDAT_W-1:0]     cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [csr_bds_pkg::VAL_W-1:0]        value_i,
  input  logic [csr_bds_pkg::COL_W-1:0]        column_i,
  input  logic                                 row_first_i,
  input  logic                                 matrix_last_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [1:0]                           kind_o,
  output logic [csr_bds_pkg::VAL_W-1:0]        entry_value_o,
  output logic [csr_bds_pkg::COL_W-1:0]        entry_column_o,
  output logic [csr_bds_pkg::ROW_W-1:0]        row_index_o,
  output logic [csr_bds_pkg::CNT_W-1:0]        d_total_o,
  output logic [csr_bds_pkg::CNT_W-1:0]        r_total_o,
  output logic                                 part_end_o,
  output logic                                 last_o
);
  import csr_bds_pkg::*;

  cfg_t               cfg_q;
  res_t               res [RES_PER_ITEM];
  logic [RES_N_W-1:0] res_n;
  res_t               head;
  logic               accept;

  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && in_ready_o;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.num_rows      <= LIM_W'(1);
      cfg_q.num_parts     <= NPART_W'(1);
      cfg_q.rows_per_part <= LIM_W'(1);
      cfg_q.lower_mode    <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_NUM_ROWS:      cfg_q.num_rows      <= cfg_data_i;
        CFG_NUM_PARTS:     cfg_q.num_parts     <= cfg_data_i[NPART_W-1:0];
        CFG_ROWS_PER_PART: cfg_q.rows_per_part <= cfg_data_i;
        CFG_LOWER_MODE:    cfg_q.lower_mode    <= cfg_data_i[0];
      endcase
    end
  end

  csr_bds_split u_split (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .accept_i      (accept),
    .value_i       (value_i),
    .column_i      (column_i),
    .row_first_i   (row_first_i),
    .matrix_last_i (matrix_last_i),
    .res_o         (res),
    .res_n_o       (res_n)
  );

  csr_bds_rq u_rq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .res_i       (res),
    .res_n_i     (res_n),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (head)
  );

  // Result word fields
  assign kind_o         = head.kind;
  assign entry_value_o  = head.value;
  assign entry_column_o = head.column;
  assign row_index_o    = head.row;
  assign d_total_o      = head.d_total;
  assign r_total_o      = head.r_total;
  assign part_end_o     = head.part_end;
  assign last_o         = head.last;

endmodule
